### sv/amix_pkg.sv
package amix_pkg;

  localparam int CH_N     = 4;
  localparam int CH_IDX_W = 2;

  typedef logic [7:0]         sample_t;   // unsigned, offset 128
  typedef logic [6:0]         vol_t;      // 0..64, larger codes clamp
  typedef logic signed [15:0] filt_t;     // filter state and output
  typedef logic signed [16:0] scaled_t;   // filt * vol / 64
  typedef logic signed [17:0] mix_t;      // sum of two scaled channels

  localparam vol_t FULL_VOL = 7'd64;

  // Control from sequencer to channel unit
  typedef struct packed {
    logic filt_en;    // capture filter result
  } chan_ctrl_t;

endpackage

### sv/four_channel_audio_mixer_top.sv
// Channel  Signals                                   Payload
// -------  ----------------------------------------  ------------------------------------
// in       in_valid / in_ready                       sample_zero..three, volume_zero..three
// out      out_valid / out_ready                     left_out, right_out, advance_cycles
// cfg      cfg_valid / cfg_ready (always ready)      cfg_data (clock_delta, 8.16)
//
// A word passes the idle state that accepts it, a filter and a scale state per channel
// through the one shared filter/multiply unit over 4 channels, and the output state
// that saturates into the output register; no new word is taken until the sequencer
// is back in idle. rst (synchronous) clears filter state, phase and out_valid and
// reloads clock_delta. A word may be taken while a frame waits; its frame then stalls
// the output step, in_ready low, until the output register frees.
module four_channel_audio_mixer_top import amix_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sample_t            sample_zero,
  input  sample_t            sample_one,
  input  sample_t            sample_two,
  input  sample_t            sample_three,
  input  vol_t               volume_zero,
  input  vol_t               volume_one,
  input  vol_t               volume_two,
  input  vol_t               volume_three,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] left_out,
  output logic signed [15:0] right_out,
  output logic [7:0]         advance_cycles,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [23:0]        cfg_data
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FILT  = 4'b0010,
    S_SCALE = 4'b0100,
    S_OUT   = 4'b1000
  } state_t;

  state_t               state, state_next;
  logic [CH_IDX_W-1:0]  ch;
  logic [23:0]          clock_delta;
  logic [15:0]          phase_fraction;
  logic [7:0]           advance;
  filt_t                fmem [CH_N];
  sample_t              samp [CH_N];
  vol_t                 vols [CH_N];
  mix_t                 acc_l, acc_r;
  logic [24:0]          phase_sum;
  logic                 in_acc, out_free;
  chan_ctrl_t           ctrl;
  filt_t                filt;
  scaled_t              scaled;
  logic signed [15:0]   sat_l, sat_r;

  assign in_ready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid || out_ready;
  assign phase_sum = {9'd0, phase_fraction} + {1'b0, clock_delta};
  assign ctrl.filt_en = (state == S_FILT);

  amix_chan_unit u_chan (
    .clk     (clk),
    .ctrl    (ctrl),
    .sample  (samp[ch]),
    .old_val (fmem[ch]),
    .volume  (vols[ch]),
    .filt    (filt),
    .scaled  (scaled)
  );

  // saturate mixes to 16 bits
  always_comb begin
    if (acc_l > 18'sd32767)       sat_l = 16'sh7FFF;
    else if (acc_l < -18'sd32768) sat_l = 16'sh8000;
    else                          sat_l = acc_l[15:0];
    if (acc_r > 18'sd32767)       sat_r = 16'sh7FFF;
    else if (acc_r < -18'sd32768) sat_r = 16'sh8000;
    else                          sat_r = acc_r[15:0];
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_acc) state_next = S_FILT;
      S_FILT:  state_next = S_SCALE;
      S_SCALE: state_next = (ch == CH_IDX_W'(CH_N - 1)) ? S_OUT : S_FILT;
      S_OUT:   if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      ch             <= '0;
      clock_delta    <= 24'd4842693;
      phase_fraction <= '0;
      out_valid      <= 1'b0;
      for (int i = 0; i < CH_N; i++) fmem[i] <= '0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) clock_delta <= cfg_data;
      if (in_acc) begin
        ch             <= '0;
        phase_fraction <= phase_sum[15:0];
      end
      if (state == S_SCALE) begin
        fmem[ch] <= filt;
        ch       <= ch + CH_IDX_W'(1);
      end
      if (state == S_OUT && out_free) out_valid <= 1'b1;
      else if (out_valid && out_ready) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      samp[0] <= sample_zero;
      samp[1] <= sample_one;
      samp[2] <= sample_two;
      samp[3] <= sample_three;
      vols[0] <= volume_zero;
      vols[1] <= volume_one;
      vols[2] <= volume_two;
      vols[3] <= volume_three;
      advance <= (phase_sum[24]) ? 8'hFF : phase_sum[23:16];
      acc_l   <= '0;
      acc_r   <= '0;
    end
    if (state == S_SCALE) begin
      // odd channels to the right
      if (ch[0]) acc_r <= acc_r + 18'(scaled);
      else       acc_l <= acc_l + 18'(scaled);
    end
    if (state == S_OUT && out_free) begin
      left_out       <= sat_l;
      right_out      <= sat_r;
      advance_cycles <= advance;
    end
  end

  a_accept_starts : assert property (@(posedge clk) disable iff (rst)
    in_acc |=> (state == S_FILT) && (ch == '0))
    else $error("accepted word did not start at channel 0");

  a_last_chan_out : assert property (@(posedge clk) disable iff (rst)
    (state == S_SCALE) && (ch == CH_IDX_W'(CH_N - 1)) |=> (state == S_OUT))
    else $error("sequencer did not reach output after last channel");

  a_hold_blocked : assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT) && out_valid && !out_ready |=> (state == S_OUT) && out_valid)
    else $error("pending result overrun");

endmodule

### sv/amix_chan_unit.sv
// Shared channel arithmetic: one-pole filter, then volume scaling.
module amix_chan_unit import amix_pkg::*; (
  input  logic       clk,
  input  chan_ctrl_t ctrl,
  input  sample_t    sample,
  input  filt_t      old_val,
  input  vol_t       volume,
  output filt_t      filt,
  output scaled_t    scaled
);

  logic signed [15:0] s_in;
  logic signed [21:0] acc;
  logic signed [21:0] acc_b;
  filt_t              filt_next;
  vol_t               vol_c;
  logic signed [23:0] prod;
  logic signed [23:0] prod_b;

  // (x - 128) * 256: flip the offset bit, shift up a byte
  assign s_in = $signed({sample ^ 8'h80, 8'h00});

  // in + 31*old, then /32 towards zero
  always_comb begin
    acc       = 22'(s_in) + (22'(old_val) <<< 5) - 22'(old_val);
    acc_b     = acc[21] ? acc + 22'sd31 : acc;
    filt_next = 16'(acc_b >>> 5);
  end

  always_ff @(posedge clk) begin
    if (ctrl.filt_en) begin
      filt <= filt_next;
    end
  end

  // filt * vol / 64 towards zero
  always_comb begin
    vol_c  = (volume > FULL_VOL) ? FULL_VOL : volume;
    prod   = 24'(filt) * $signed({17'd0, vol_c});
    prod_b = prod[23] ? prod + 24'sd63 : prod;
    scaled = 17'(prod_b >>> 6);
  end

endmodule
